/* hw/rtl/thkr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package thkr_pkg;

    // Default number of tap-hold keys
    localparam int TH_NUM_KEYS = 12;

    // Fixed field widths
    localparam int KEY_W   = 4;
    localparam int DELAY_W = 16;
    localparam int TIME_W  = 16;

    localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd200;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic cap;            // capture the accepted request
        logic walk_inc;       // step the key walk on
        logic emit;           // push a new result
        logic emit_src_walk;  // result key from the walk index, else from the request
        logic emit_hold;      // hold code selection
        logic emit_reg;       // press (1) or release (0)
        logic clr_pend_walk;  // clear pending of the walked key
        logic clr_pend_key;   // clear pending of the request key
        logic set_dh;         // mark the request key as double held
        logic clr_dh;         // drop the double held mark
        logic arm;            // record a fresh dual press
        logic flush;          // send the held result as the final one
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic mode;
        logic key_down;
        logic walk_hit;
        logic walk_last;
        logic ev_valid;
        logic ev_dbl;
        logic ev_pend;
        logic ev_dh;
        logic held_valid;
        logic adv;
    } t_status;

endpackage

`default_nettype wire

/* hw/rtl/thkr_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module thkr_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire thkr_pkg::t_status i_status,
    output thkr_pkg::t_cmd         o_cmd,
    output logic                  o_busy
);
    import thkr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_WALK  = 4'b0010,
        S_EVENT = 4'b0100,
        S_FLUSH = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_ph, n_ph;
    t_cmd   cmd;

    // Sequence one request: key walk for scans and presses, key event for events, final flush
    always_comb begin
        n_state = r_state;
        n_ph    = r_ph;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    cmd.cap = 1'b1;
                    n_ph    = 1'b0;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                // scans and presses walk the keys, releases go straight on
                if (i_status.mode && !i_status.key_down) begin
                    n_state = S_EVENT;
                end else if (!r_ph) begin
                    if (i_status.walk_hit) begin
                        if (i_status.adv) begin
                            cmd.emit          = 1'b1;
                            cmd.emit_src_walk = 1'b1;
                            cmd.emit_hold     = !i_status.mode;
                            cmd.emit_reg      = 1'b1;
                            n_ph              = 1'b1;
                        end
                    end else begin
                        cmd.walk_inc = 1'b1;
                        if (i_status.walk_last) begin
                            n_state = i_status.mode ? S_EVENT : S_FLUSH;
                        end
                    end
                end else if (i_status.adv) begin
                    cmd.emit          = 1'b1;
                    cmd.emit_src_walk = 1'b1;
                    cmd.emit_hold     = !i_status.mode;
                    cmd.emit_reg      = 1'b0;
                    cmd.clr_pend_walk = 1'b1;
                    cmd.walk_inc      = 1'b1;
                    n_ph              = 1'b0;
                    if (i_status.walk_last) begin
                        n_state = i_status.mode ? S_EVENT : S_FLUSH;
                    end
                end
            end
            S_EVENT: begin
                if (!i_status.ev_valid) begin
                    n_state = S_FLUSH;
                end else if (i_status.key_down) begin
                    if (i_status.ev_dbl) begin
                        if (i_status.adv) begin
                            cmd.emit     = 1'b1;
                            cmd.emit_reg = 1'b1;
                            cmd.set_dh   = 1'b1;
                            n_state      = S_FLUSH;
                        end
                    end else begin
                        cmd.arm = 1'b1;
                        n_state = S_FLUSH;
                    end
                end else if (i_status.ev_pend) begin
                    if (i_status.adv) begin
                        cmd.emit = 1'b1;
                        if (!r_ph) begin
                            cmd.emit_reg = 1'b1;
                            n_ph         = 1'b1;
                        end else begin
                            cmd.clr_pend_key = 1'b1;
                            n_ph             = 1'b0;
                            n_state          = S_FLUSH;
                        end
                    end
                end else if (i_status.ev_dh) begin
                    if (i_status.adv) begin
                        cmd.emit   = 1'b1;
                        cmd.clr_dh = 1'b1;
                        n_state    = S_FLUSH;
                    end
                end else begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!i_status.held_valid) begin
                    n_state = S_IDLE;
                end else if (i_status.adv) begin
                    cmd.flush = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ph    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ph    <= n_ph;
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != S_IDLE);

    // A result is never pushed into a full output stage that is stalled
    a_emit_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit || cmd.flush) |-> i_status.adv)
        else $error("push without room");

    // A request is only captured while nothing is in flight
    a_cap_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.cap |-> (r_state == S_IDLE) && !i_status.held_valid)
        else $error("capture while busy");

    // A flush with nothing held always returns to idle
    a_flush_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH) && !i_status.held_valid |=> (r_state == S_IDLE))
        else $error("flush did not finish");

endmodule

`default_nettype wire

/* hw/rtl/thkr_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module thkr_dp #(
    parameter int NUM_KEYS = thkr_pkg::TH_NUM_KEYS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire thkr_pkg::t_cmd                 i_cmd,
    output thkr_pkg::t_status                   o_status,
    input  wire logic                          i_cfg_we,
    input  wire logic [thkr_pkg::DELAY_W-1:0]  i_cfg_wdata,
    input  wire logic                          i_mode,
    input  wire logic [thkr_pkg::TIME_W-1:0]   i_now_ms,
    input  wire logic                          i_is_dual_key,
    input  wire logic [thkr_pkg::KEY_W-1:0]    i_key_index,
    input  wire logic                          i_key_down,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [thkr_pkg::KEY_W-1:0]         o_out_key,
    output logic                               o_use_hold_code,
    output logic                               o_register_res,
    output logic                               o_last
);
    import thkr_pkg::*;

    localparam int IW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    // Request registers
    logic               r_mode, r_dual, r_down;
    logic [TIME_W-1:0]  r_now;
    logic [KEY_W-1:0]   r_key;

    // Key state
    logic [DELAY_W-1:0] r_delay;
    logic [NUM_KEYS-1:0] r_pend, r_dh;
    logic [TIME_W-1:0]  r_stamp [NUM_KEYS];
    logic               r_prev_valid;
    logic [KEY_W-1:0]   r_prev_key;
    logic [TIME_W-1:0]  r_prev_stamp;

    // Walk index
    logic [IW-1:0]      r_idx;

    // Held result and output stage
    logic               r_hv, r_h_hold, r_h_reg;
    logic [KEY_W-1:0]   r_h_key;
    logic               r_ov, r_o_hold, r_o_reg, r_o_last;
    logic [KEY_W-1:0]   r_o_key;

    logic [31:0]        key_ext, idx_ext;
    logic [IW-1:0]      key_idx;
    logic [TIME_W-1:0]  walk_el, prev_el;
    logic [KEY_W-1:0]   new_key;
    logic               out_take, push_out;

    assign key_ext = 32'(r_key);
    assign idx_ext = 32'(r_idx);
    assign key_idx = key_ext[IW-1:0];
    assign walk_el = r_now - r_stamp[r_idx];
    assign prev_el = r_now - r_prev_stamp;
    assign new_key = i_cmd.emit_src_walk ? idx_ext[KEY_W-1:0] : r_key;

    assign out_take = r_ov && !i_out_stall;
    assign push_out = (i_cmd.emit && r_hv) || i_cmd.flush;

    // Status
    always_comb begin
        o_status.mode       = r_mode;
        o_status.key_down   = r_down;
        o_status.walk_hit   = r_pend[r_idx] && (r_mode || (walk_el > r_delay));
        o_status.walk_last  = (idx_ext == 32'(NUM_KEYS - 1));
        o_status.ev_valid   = r_dual && (key_ext < 32'(NUM_KEYS));
        o_status.ev_dbl     = r_prev_valid && (r_prev_key == r_key) && (prev_el < r_delay);
        o_status.ev_pend    = r_pend[key_idx];
        o_status.ev_dh      = r_dh[key_idx];
        o_status.held_valid = r_hv;
        o_status.adv        = !r_ov || !i_out_stall;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay      <= DELAY_RESET;
            r_pend       <= '0;
            r_dh         <= '0;
            r_prev_valid <= 1'b0;
            r_idx        <= '0;
            r_hv         <= 1'b0;
            r_ov         <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_delay <= i_cfg_wdata;
            end
            if (i_cmd.cap) begin
                r_idx <= '0;
            end else if (i_cmd.walk_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.clr_pend_walk) begin
                r_pend[r_idx] <= 1'b0;
            end
            if (i_cmd.clr_pend_key) begin
                r_pend[key_idx] <= 1'b0;
            end
            if (i_cmd.arm) begin
                r_pend[key_idx] <= 1'b1;
                r_prev_valid    <= 1'b1;
            end
            if (i_cmd.set_dh) begin
                r_dh[key_idx] <= 1'b1;
            end
            if (i_cmd.clr_dh) begin
                r_dh[key_idx] <= 1'b0;
            end
            // advance the held result and the output stage
            if (i_cmd.emit) begin
                r_hv <= 1'b1;
            end else if (i_cmd.flush) begin
                r_hv <= 1'b0;
            end
            if (push_out) begin
                r_ov <= 1'b1;
            end else if (out_take) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_mode <= i_mode;
            r_now  <= i_now_ms;
            r_dual <= i_is_dual_key;
            r_key  <= i_key_index;
            r_down <= i_key_down;
        end
        if (i_cmd.arm) begin
            r_stamp[key_idx] <= r_now;
            r_prev_key       <= r_key;
            r_prev_stamp     <= r_now;
        end
        if (i_cmd.emit) begin
            r_h_key  <= new_key;
            r_h_hold <= i_cmd.emit_hold;
            r_h_reg  <= i_cmd.emit_reg;
        end
        if (push_out) begin
            r_o_key  <= r_h_key;
            r_o_hold <= r_h_hold;
            r_o_reg  <= r_h_reg;
            r_o_last <= i_cmd.flush;
        end
    end

    assign o_out_valid     = r_ov;
    assign o_out_key       = r_o_key;
    assign o_use_hold_code = r_o_hold;
    assign o_register_res  = r_o_reg;
    assign o_last          = r_o_last;

    // Flush only sends a result that exists
    a_flush_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.flush |-> r_hv)
        else $error("flush with nothing held");

    // A stalled output is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_out |-> !(r_ov && i_out_stall))
        else $error("output overwritten under stall");

    // The last flag is set exactly by a flush
    a_last_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_out |=> (r_o_last == $past(i_cmd.flush)))
        else $error("last flag mismatch");

endmodule

`default_nettype wire

/* hw/rtl/tap_hold_key_resolver.sv */
`timescale 1ns / 1ps
`default_nettype none
// Tap-or-hold resolver for a row of dual-function keys.
// Input channel (i_in_valid / o_in_stall) carries one request: a periodic
// scan (mode 0) or a key press/release event (mode 1). Output channel
// (o_out_valid / i_out_stall) carries results: key index, tap or hold code,
// press or release, and a last flag on the final result of each request.
// A request that causes nothing produces no result.
// One request is worked on at a time; o_in_stall is high until it is done.
// A scan or press walks all NUM_KEYS keys, one step per key plus one more per
// key that resolves (two results); a press adds one event step, a release
// skips the walk and takes one or two event steps, and each request ends
// with one close-out step. Each result waits in a one-deep hold register until
// the next result or the close-out moves it to the output register.
// A stall on the output holds the walk at the next result; nothing is lost.
// i_cfg_we writes the hold delay (reset 200 ms); write only while idle.
// Synchronous reset clears all pending and double-tap marks and the output.
module tap_hold_key_resolver #(
    parameter int NUM_KEYS = thkr_pkg::TH_NUM_KEYS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [thkr_pkg::DELAY_W-1:0]  i_cfg_wdata,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_mode,
    input  wire logic [thkr_pkg::TIME_W-1:0]   i_now_ms,
    input  wire logic                          i_is_dual_key,
    input  wire logic [thkr_pkg::KEY_W-1:0]    i_key_index,
    input  wire logic                          i_key_down,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [thkr_pkg::KEY_W-1:0]         o_out_key,
    output logic                               o_use_hold_code,
    output logic                               o_register_res,
    output logic                               o_last
);
    import thkr_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    busy;

    assign o_in_stall = busy;

    thkr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (i_in_valid && !busy),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    thkr_dp #(
        .NUM_KEYS (NUM_KEYS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_mode          (i_mode),
        .i_now_ms        (i_now_ms),
        .i_is_dual_key   (i_is_dual_key),
        .i_key_index     (i_key_index),
        .i_key_down      (i_key_down),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_key       (o_out_key),
        .o_use_hold_code (o_use_hold_code),
        .o_register_res  (o_register_res),
        .o_last          (o_last)
    );

endmodule

`default_nettype wire

/* tb/sv/thkr_tb_pkg.sv */
`timescale 1ns / 1ps

package thkr_tb_pkg;

    import thkr_pkg::*;

    // Request and result codes
    localparam bit MODE_SCAN   = 1'b0;
    localparam bit MODE_EVENT  = 1'b1;
    localparam bit CODE_TAP    = 1'b0;
    localparam bit CODE_HOLD   = 1'b1;
    localparam bit REG_RELEASE = 1'b0;
    localparam bit REG_PRESS   = 1'b1;

    // Cap on printed mismatch lines; counting goes on past it
    localparam int MAX_REPORTS = 100;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             hold;
        logic             press;
        logic             last;
    } key_code_t;

    // Tracks key state per request and holds the codes still to arrive
    class tap_hold_scoreboard;

        logic [DELAY_W-1:0] hold_delay;
        bit                 pend_flag [TH_NUM_KEYS];
        bit                 dbl_flag  [TH_NUM_KEYS];
        logic [TIME_W-1:0]  press_time[TH_NUM_KEYS];
        logic [KEY_W-1:0]   last_key;
        bit                 last_key_ok;
        logic [TIME_W-1:0]  last_press_time;
        key_code_t          fresh_codes[$];
        key_code_t          awaited_codes[$];
        int unsigned        errors;

        function new();
            hold_delay      = DELAY_RESET;
            last_key        = '0;
            last_key_ok     = 1'b0;
            last_press_time = '0;
            errors          = 0;
            for (int i = 0; i < TH_NUM_KEYS; i++) begin
                pend_flag[i]  = 1'b0;
                dbl_flag[i]   = 1'b0;
                press_time[i] = '0;
            end
        endfunction

        function void set_delay(logic [DELAY_W-1:0] value);
            hold_delay = value;
        endfunction

        function int unsigned waiting();
            return awaited_codes.size();
        endfunction

        function void add_code(logic [KEY_W-1:0] key, bit hold, bit press);
            fresh_codes.push_back('{key, hold, press, 1'b0});
        endfunction

        // Walk the keys upward; as taps resolve all, as holds only the expired ones
        function void resolve_pending(bit as_hold, logic [TIME_W-1:0] now);
            logic [TIME_W-1:0] gone;
            for (int i = 0; i < TH_NUM_KEYS; i++) begin
                gone = now - press_time[i];
                if (pend_flag[i] && (!as_hold || gone > hold_delay)) begin
                    add_code(KEY_W'(i), as_hold ? CODE_HOLD : CODE_TAP, REG_PRESS);
                    add_code(KEY_W'(i), as_hold ? CODE_HOLD : CODE_TAP, REG_RELEASE);
                    pend_flag[i] = 1'b0;
                end
            end
        endfunction

        // Predict the codes caused by one accepted request
        function void note_request(bit mode, logic [TIME_W-1:0] now, bit dual,
                                   logic [KEY_W-1:0] key, bit down);
            logic [TIME_W-1:0] since_last;
            since_last = now - last_press_time;
            if (mode == MODE_SCAN) begin
                resolve_pending(1'b1, now);
            end else begin
                if (down)
                    resolve_pending(1'b0, now);
                if (dual && key < TH_NUM_KEYS) begin
                    if (down) begin
                        if (last_key_ok && last_key == key && since_last < hold_delay) begin
                            // second press inside the window: hold the tap down
                            add_code(key, CODE_TAP, REG_PRESS);
                            dbl_flag[key] = 1'b1;
                        end else begin
                            last_key        = key;
                            last_key_ok     = 1'b1;
                            last_press_time = now;
                            press_time[key] = now;
                            pend_flag[key]  = 1'b1;
                        end
                    end else if (pend_flag[key]) begin
                        add_code(key, CODE_TAP, REG_PRESS);
                        add_code(key, CODE_TAP, REG_RELEASE);
                        pend_flag[key] = 1'b0;
                    end else if (dbl_flag[key]) begin
                        add_code(key, CODE_TAP, REG_RELEASE);
                        dbl_flag[key] = 1'b0;
                    end
                end
            end
            if (fresh_codes.size() > 0)
                fresh_codes[fresh_codes.size()-1].last = 1'b1;
            foreach (fresh_codes[i])
                awaited_codes.push_back(fresh_codes[i]);
            fresh_codes.delete();
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            end
        endfunction

        // Compare one delivered code with the oldest awaited one
        function void check_result(logic [KEY_W-1:0] key, bit hold, bit press, bit last);
            key_code_t want;
            if (awaited_codes.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: expected no result, got key %0d hold %0b press %0b last %0b",
                             $time, key, hold, press, last);
                return;
            end
            want = awaited_codes.pop_front();
            compare_field("out_key", want.key, key);
            compare_field("use_hold_code", want.hold, hold);
            compare_field("register_res", want.press, press);
            compare_field("last", want.last, last);
        endfunction

        function void report_leftover();
            if (awaited_codes.size() != 0) begin
                errors += awaited_codes.size();
                $display("%0t: expected %0d more results, got none", $time,
                         awaited_codes.size());
            end
        endfunction

    endclass

endpackage

/* tb/sv/tap_hold_key_resolver_tb.sv */
`timescale 1ns / 1ps

module tap_hold_key_resolver_tb;

    import thkr_pkg::*;
    import thkr_tb_pkg::*;

    localparam int CYCLE_LIMIT     = 2000000;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int SETTLE_CYCLES   = 64;
    localparam int HOLD_OFF_CYCLES = 300;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_cfg_we       = 1'b0;
    logic [DELAY_W-1:0]   i_cfg_wdata    = '0;
    logic                 i_in_valid     = 1'b0;
    logic                 o_in_stall;
    logic                 i_mode         = 1'b0;
    logic [TIME_W-1:0]    i_now_ms       = '0;
    logic                 i_is_dual_key  = 1'b0;
    logic [KEY_W-1:0]     i_key_index    = '0;
    logic                 i_key_down     = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall    = 1'b0;
    logic [KEY_W-1:0]     o_out_key;
    logic                 o_use_hold_code;
    logic                 o_register_res;
    logic                 o_last;

    tap_hold_scoreboard   codes_sb;
    bit                   idle_on        = 1'b1;
    int unsigned          n_sent         = 0;
    int unsigned          cycle_count    = 0;
    int unsigned          hold_off_reqs  = 0;
    int unsigned          hold_off_done  = 0;
    int                   hold_off_left  = 0;
    int                   stall_left     = 0;
    logic [TIME_W-1:0]    now_t          = '0;
    logic [DELAY_W-1:0]   cur_delay      = DELAY_RESET;

    tap_hold_key_resolver dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_mode          (i_mode),
        .i_now_ms        (i_now_ms),
        .i_is_dual_key   (i_is_dual_key),
        .i_key_index     (i_key_index),
        .i_key_down      (i_key_down),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_key       (o_out_key),
        .o_use_hold_code (o_use_hold_code),
        .o_register_res  (o_register_res),
        .o_last          (o_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Count cycles and give up at the limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    // Watch both handshakes; pre-edge values decide acceptance
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                codes_sb.check_result(o_out_key, o_use_hold_code, o_register_res, o_last);
            if (i_in_valid && !o_in_stall)
                codes_sb.note_request(i_mode, i_now_ms, i_is_dual_key, i_key_index,
                                      i_key_down);
        end
    end

    // Drive receiver stall: long hold-offs on request, else random bursts while idle_on
    always @(posedge i_clk) begin
        if (hold_off_left > 0) begin
            i_out_stall   <= 1'b1;
            hold_off_left <= hold_off_left - 1;
        end else if (hold_off_done != hold_off_reqs) begin
            i_out_stall   <= 1'b1;
            hold_off_done <= hold_off_done + 1;
            hold_off_left <= HOLD_OFF_CYCLES - 1;
        end else if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(0, 15);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Offer one request and hold it until accepted
    task automatic send_request(input bit mode, input logic [TIME_W-1:0] now,
                                input bit dual, input logic [KEY_W-1:0] key,
                                input bit down);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_mode        <= mode;
        i_now_ms      <= now;
        i_is_dual_key <= dual;
        i_key_index   <= key;
        i_key_down    <= down;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        n_sent++;
    endtask

    // Scan requests carry random filler in the fields they do not use
    task automatic scan_at(input logic [TIME_W-1:0] now);
        send_request(MODE_SCAN, now, 1'($urandom_range(0, 1)),
                     KEY_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    endtask

    task automatic key_event(input logic [TIME_W-1:0] now, input bit dual,
                             input logic [KEY_W-1:0] key, input bit down);
        send_request(MODE_EVENT, now, dual, key, down);
    endtask

    // Drop valid, wait out every awaited code, then let the block go quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (codes_sb.waiting() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_delay(input logic [DELAY_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_delay    = value;
        codes_sb.set_delay(value);
    endtask

    // Time steps cluster around the delay boundary, with some wild jumps
    function automatic logic [TIME_W-1:0] advance();
        logic [TIME_W-1:0] dt;
        case ($urandom_range(0, 7))
            0: dt = '0;
            1: dt = cur_delay - 16'd1;
            2: dt = cur_delay;
            3: dt = cur_delay + 16'd1;
            4: dt = TIME_W'($urandom_range(0, 63));
            5: dt = TIME_W'($urandom_range(0, cur_delay));
            6: dt = TIME_W'($urandom_range(0, 2 * cur_delay + 2));
            default: dt = TIME_W'($urandom);
        endcase
        now_t = now_t + dt;
        return now_t;
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 7) == 0)
            return KEY_W'($urandom_range(TH_NUM_KEYS, 15));
        return KEY_W'($urandom_range(0, TH_NUM_KEYS - 1));
    endfunction

    // One random key sequence: mostly well formed, some noise
    task automatic random_sequence();
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] k2;
        bit               dual2;
        k     = pick_key();
        k2    = pick_key();
        dual2 = ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 9))
            0, 1: begin
                // tap, sometimes with a scan in between
                key_event(advance(), 1'b1, k, 1'b1);
                if ($urandom_range(0, 1) == 1)
                    scan_at(advance());
                key_event(advance(), 1'b1, k, 1'b0);
            end
            2, 3: begin
                // hold through one or two scans
                key_event(advance(), 1'b1, k, 1'b1);
                scan_at(advance());
                if ($urandom_range(0, 1) == 1)
                    scan_at(advance());
                key_event(advance(), 1'b1, k, 1'b0);
            end
            4, 5: begin
                // double tap
                key_event(advance(), 1'b1, k, 1'b1);
                key_event(advance(), 1'b1, k, 1'b0);
                key_event(advance(), 1'b1, k, 1'b1);
                key_event(advance(), 1'b1, k, 1'b0);
            end
            6: begin
                // roll onto a second key
                key_event(advance(), 1'b1, k, 1'b1);
                key_event(advance(), dual2, k2, 1'b1);
                key_event(advance(), 1'b1, k, 1'b0);
                key_event(advance(), dual2, k2, 1'b0);
            end
            7: begin
                // repeat press without a release
                key_event(advance(), 1'b1, k, 1'b1);
                key_event(advance(), 1'b1, k, 1'b1);
                key_event(advance(), 1'b1, k, 1'b0);
            end
            8: scan_at(advance());
            default: begin
                send_request(1'($urandom_range(0, 1)), TIME_W'($urandom),
                             1'($urandom_range(0, 1)), KEY_W'($urandom_range(0, 15)),
                             1'($urandom_range(0, 1)));
            end
        endcase
    endtask

    task automatic random_phase(input int unsigned until_sent);
        while (n_sent < until_sent) random_sequence();
    endtask

    initial begin
        int drain;
        codes_sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed requests at the reset delay of 200 ms
        scan_at(16'd0);
        key_event(16'd10, 1'b0, 4'd2, 1'b1);
        key_event(16'd20, 1'b1, 4'd5, 1'b0);
        key_event(16'd1000, 1'b1, 4'd0, 1'b1);
        scan_at(16'd1200);
        scan_at(16'd1201);
        key_event(16'd2000, 1'b1, 4'd11, 1'b1);
        key_event(16'd2050, 1'b1, 4'd11, 1'b0);
        key_event(16'd2100, 1'b1, 4'd11, 1'b1);
        key_event(16'd2400, 1'b1, 4'd11, 1'b0);
        key_event(16'd3000, 1'b1, 4'd3, 1'b1);
        key_event(16'd3010, 1'b1, 4'd7, 1'b1);
        key_event(16'd3020, 1'b0, 4'd9, 1'b1);
        key_event(16'd3100, 1'b1, 4'd3, 1'b1);
        key_event(16'd3110, 1'b1, 4'd15, 1'b1);
        key_event(16'd4000, 1'b1, 4'd4, 1'b1);
        key_event(16'd4050, 1'b1, 4'd4, 1'b1);
        key_event(16'd4060, 1'b1, 4'd4, 1'b0);
        // press just before the time wraps, expire just after it
        key_event(16'hFFD0, 1'b1, 4'd9, 1'b1);
        scan_at(16'd152);
        scan_at(16'd153);
        // second press exactly at the window edge is a fresh press
        key_event(16'd5000, 1'b1, 4'd6, 1'b1);
        key_event(16'd5010, 1'b1, 4'd6, 1'b0);
        key_event(16'd5200, 1'b1, 4'd6, 1'b1);
        key_event(16'd5399, 1'b1, 4'd6, 1'b1);
        key_event(16'd5400, 1'b1, 4'd6, 1'b0);
        now_t = 16'd5400;

        settle();
        write_delay(16'd0);
        random_phase(100);

        // Hold the receiver off while requests keep coming
        settle();
        write_delay(16'hFFFF);
        hold_off_reqs++;
        random_phase(170);

        settle();
        write_delay(16'd1);
        random_phase(240);

        settle();
        write_delay(DELAY_W'($urandom_range(2, 400)));
        random_phase(320);

        // Last stretch at full rate with no idling
        settle();
        write_delay(DELAY_RESET);
        idle_on = 1'b0;
        random_phase(420);

        i_in_valid <= 1'b0;
        drain = 0;
        while (codes_sb.waiting() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        codes_sb.report_leftover();

        if (codes_sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/thkr_pkg.sv
hw/rtl/thkr_ctrl.sv
hw/rtl/thkr_dp.sv
hw/rtl/tap_hold_key_resolver.sv
tb/sv/thkr_tb_pkg.sv
tb/sv/tap_hold_key_resolver_tb.sv
